/* rtl/ctfd_pkg.sv */
package ctfd_pkg;

  localparam logic [7:0]  FRAME_START  = 8'h01;
  localparam logic [7:0]  FRAME_SECOND = 8'hFF;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'hA001;

  typedef enum logic [5:0] {
    POS_START  = 6'b000001,
    POS_SECOND = 6'b000010,
    POS_FREE0  = 6'b000100,
    POS_FREE1  = 6'b001000,
    POS_CHK_HI = 6'b010000,
    POS_CHK_LO = 6'b100000
  } pos_t;

  typedef struct packed {
    logic crc_error;
    logic trigger;
  } result_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* rtl/crc_checked_trigger_frame_detector.sv */
// Upgrade-request frame detector with CRC-16/Modbus check.
//
// Input channel (in_*): one received serial byte per item in in_tdata.
// Result channel (out_*): exactly one item per input item, in order.
//   out_tdata[0] is trigger: a six-byte frame 01 FF xx xx CRChi CRClo
//   ended here and its CRC over the first four bytes matched.
//   out_tdata[1] is crc_error: such a frame ended here with a wrong CRC.
//   Both bits are 0 on every other byte.
// Path: an accepted byte is captured in the input register, and its result
// is then held in the result register that drives out_tvalid.
// Throughput: one item per cycle while out_tready is high; the CRC is updated
// for a whole byte by one block of fixed logic after the input register.
// Stall: when out_tready is low the result register holds its item, the
// input register still fills once, and in_tready drops only when both are
// occupied; nothing is lost or repeated.
// Reset (rst_n low, synchronous): both registers empty, the hunt restarts
// at the frame start with the CRC at its initial value.
module crc_checked_trigger_frame_detector (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rx_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [0] trigger, [1] crc_error, [7:2] zero
);
  import ctfd_pkg::*;

  logic        in_v_r;
  logic [7:0]  in_byte_r;
  logic        out_v_r;
  result_t     res_r;
  result_t     res_nxt;
  pos_t        pos_r;
  pos_t        pos_nxt;
  logic [15:0] crc_r;
  logic [15:0] crc_nxt;
  logic [7:0]  chk_hi_r;
  logic [7:0]  chk_hi_nxt;
  logic [15:0] crc_fed;
  logic        out_free;
  logic        advance;

  assign out_free  = !out_v_r || out_tready;
  assign advance   = in_v_r && out_free;
  assign in_tready = !in_v_r || advance;

  assign crc_fed = crc_feed(crc_r, in_byte_r);

  always_comb begin
    pos_nxt    = pos_r;
    crc_nxt    = crc_r;
    chk_hi_nxt = chk_hi_r;
    res_nxt    = '0;
    case (pos_r)
      POS_START: begin
        if (in_byte_r == FRAME_START) begin
          crc_nxt = crc_fed;
          pos_nxt = POS_SECOND;
        end
      end
      POS_SECOND: begin
        if (in_byte_r == FRAME_SECOND) begin
          crc_nxt = crc_fed;
          pos_nxt = POS_FREE0;
        end else begin
          pos_nxt    = POS_START;
          crc_nxt    = CRC_INIT;
          chk_hi_nxt = '0;
        end
      end
      POS_FREE0: begin
        crc_nxt = crc_fed;
        pos_nxt = POS_FREE1;
      end
      POS_FREE1: begin
        crc_nxt = crc_fed;
        pos_nxt = POS_CHK_HI;
      end
      POS_CHK_HI: begin
        chk_hi_nxt = in_byte_r;
        pos_nxt    = POS_CHK_LO;
      end
      POS_CHK_LO: begin
        if (crc_r == {chk_hi_r, in_byte_r}) begin
          res_nxt.trigger = 1'b1;
        end else begin
          res_nxt.crc_error = 1'b1;
        end
        pos_nxt    = POS_START;
        crc_nxt    = CRC_INIT;
        chk_hi_nxt = '0;
      end
      default: begin
        pos_nxt    = POS_START;
        crc_nxt    = CRC_INIT;
        chk_hi_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      pos_r    <= POS_START;
      crc_r    <= CRC_INIT;
      chk_hi_r <= '0;
    end else begin
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end
      if (advance) begin
        out_v_r  <= 1'b1;
        pos_r    <= pos_nxt;
        crc_r    <= crc_nxt;
        chk_hi_r <= chk_hi_nxt;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {6'b000000, res_r};

endmodule

/* rtl/ctfd_checker.sv */
module ctfd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  logic in_acc;
  assign in_acc = in_tvalid && in_tready && (in_tdata == in_tdata);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result item changed");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("trigger and crc_error both set");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:2] == 6'b000000)
    else $error("result padding not zero");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not empty after reset");

  a_no_result_without_input: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid && !in_acc |=> !($past(in_tready) == 1'b1 && out_tvalid && !$past(out_tvalid)
                                 && !$past(in_acc, 2) && $past(in_tready, 2)))
    else $error("result item without an accepted input item");

endmodule

bind crc_checked_trigger_frame_detector ctfd_checker u_ctfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
